// ----- src/bnd_pkg.sv -----
// Shared types, constants and the neighbour test of the binary dilation unit.
package bnd_pkg;

    localparam int MAX_WIDTH = 1024;
    localparam int COL_BITS  = $clog2(MAX_WIDTH);
    localparam int WCFG_BITS = 11;
    localparam int ROW_BITS  = 16;
    localparam int RCNT_BITS = ROW_BITS + 1;
    localparam int ADDR_BITS = 4;

    // Register indexes, taken from paddr[3:2].
    localparam logic [1:0] REG_EIGHT  = 2'd0;
    localparam logic [1:0] REG_WIDTH  = 2'd1;
    localparam logic [1:0] REG_HEIGHT = 2'd2;

    // Input beat kinds carried in tuser.
    localparam logic REQ_PIXEL = 1'b0;
    localparam logic REQ_DRAIN = 1'b1;

    localparam logic [WCFG_BITS-1:0] WIDTH_RESET  = WCFG_BITS'(1024);
    localparam logic [ROW_BITS-1:0]  HEIGHT_RESET = ROW_BITS'(1024);

    // Effective configuration seen by the datapath.
    typedef struct packed {
        logic                 eight_connected;
        logic [WCFG_BITS-1:0] width;
        logic [ROW_BITS-1:0]  height;
        logic                 restart;
    } cfg_t;

    // One item between the scan stage and the window stage.
    typedef struct packed {
        logic [COL_BITS-1:0] addr;
        logic                px;
        logic                emit;
        logic                emit_prev;
        logic                lv;
        logic                rv;
        logic                up;
        logic                dn;
        logic                last;
        logic [COL_BITS-1:0] oc;
        logic [ROW_BITS-1:0] orow;
    } item_t;

    // Each column holds bit 0 upper row, bit 1 centre row, bit 2 lower row.
    function automatic logic dilate(input logic [2:0] left, input logic [2:0] mid,
                                    input logic [2:0] right, input logic lv,
                                    input logic rv, input logic up, input logic dn,
                                    input logic eight);
        logic hit;
        hit = (up & mid[0]) | (dn & mid[2]) | (lv & left[1]) | (rv & right[1]);
        hit = hit | (eight & ((lv & up & left[0]) | (lv & dn & left[2])
                            | (rv & up & right[0]) | (rv & dn & right[2])));
        return hit;
    endfunction

endpackage

// ----- src/bnd_cfg_regs.sv -----
// APB register block holding connectivity and image geometry.
module bnd_cfg_regs
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [bnd_pkg::ADDR_BITS-1:0]  paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    output bnd_pkg::cfg_t                  cfg
);

    logic                              eight_reg;
    logic [bnd_pkg::WCFG_BITS-1:0]     width_reg;
    logic [bnd_pkg::ROW_BITS-1:0]      height_reg;
    logic                              wr;
    logic [1:0]                        idx;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;
    assign idx    = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eight_reg  <= 1'b1;
            width_reg  <= bnd_pkg::WIDTH_RESET;
            height_reg <= bnd_pkg::HEIGHT_RESET;
        end
        else if (wr)
        begin
            case (idx)
                bnd_pkg::REG_EIGHT:  eight_reg  <= pwdata[0];
                bnd_pkg::REG_WIDTH:  width_reg  <= pwdata[bnd_pkg::WCFG_BITS-1:0];
                bnd_pkg::REG_HEIGHT: height_reg <= pwdata[bnd_pkg::ROW_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            bnd_pkg::REG_EIGHT:  prdata = {31'd0, eight_reg};
            bnd_pkg::REG_WIDTH:  prdata = {{(32-bnd_pkg::WCFG_BITS){1'b0}}, width_reg};
            bnd_pkg::REG_HEIGHT: prdata = {{(32-bnd_pkg::ROW_BITS){1'b0}}, height_reg};
            default:             prdata = 32'd0;
        endcase
    end

    // Out-of-range geometry is clamped here so the datapath sees legal values.
    always_comb
    begin
        cfg.eight_connected = eight_reg;
        if (width_reg == '0)
            cfg.width = bnd_pkg::WCFG_BITS'(1);
        else if (width_reg > bnd_pkg::WCFG_BITS'(bnd_pkg::MAX_WIDTH))
            cfg.width = bnd_pkg::WCFG_BITS'(bnd_pkg::MAX_WIDTH);
        else
            cfg.width = width_reg;
        cfg.height  = (height_reg == '0) ? bnd_pkg::ROW_BITS'(1) : height_reg;
        cfg.restart = wr && ((idx == bnd_pkg::REG_WIDTH) || (idx == bnd_pkg::REG_HEIGHT));
    end

endmodule

// ----- src/bnd_line_mem.sv -----
// Two-row line memory, one read and one write port, write-through on a same-address hit.
module bnd_line_mem
(
    input  logic                          clk,
    input  logic                          ren,
    input  logic [bnd_pkg::COL_BITS-1:0]  raddr,
    output logic [1:0]                    rdata,
    input  logic                          wen,
    input  logic [bnd_pkg::COL_BITS-1:0]  waddr,
    input  logic [1:0]                    wdata
);

    // Bit 1 holds the older row, bit 0 the newer row.
    logic [1:0] mem [bnd_pkg::MAX_WIDTH];

    always_ff @(posedge clk)
    begin
        if (wen)
            mem[waddr] <= wdata;
        if (ren)
        begin
            if (wen && (waddr == raddr))
                rdata <= wdata;
            else
                rdata <= mem[raddr];
        end
    end

endmodule

// ----- src/bnd_raster_ctrl.sv -----
// Raster position counters and the scan stage that issues line memory reads.
module bnd_raster_ctrl
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  bnd_pkg::cfg_t                 cfg,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic                          req_type,
    input  logic                          pixel_black,
    input  logic                          s1_go,
    output logic                          s1_valid,
    output bnd_pkg::item_t                s1_item,
    output logic                          mem_ren,
    output logic [bnd_pkg::COL_BITS-1:0]  mem_raddr
);

    logic [bnd_pkg::COL_BITS-1:0]  ic_reg, ic_next;
    logic [bnd_pkg::RCNT_BITS-1:0] ri_reg, ri_next;
    logic                          s1_valid_reg;
    bnd_pkg::item_t                item_reg, item_next;
    logic                          drain, skip, acc, take;
    logic [bnd_pkg::RCNT_BITS-1:0] h_ext, ri_m1, ri_m2;
    logic [bnd_pkg::WCFG_BITS-1:0] ic_inc, w_m1;
    logic [bnd_pkg::COL_BITS-1:0]  ic_m1;

    assign s_tready  = !s1_valid_reg || s1_go;
    assign acc       = s_tvalid && s_tready;
    assign drain     = (req_type == bnd_pkg::REQ_DRAIN);
    assign skip      = drain && (ic_reg == '0) && (ri_reg == '0);
    assign take      = acc && !skip;
    assign mem_ren   = take;
    assign mem_raddr = ic_reg;
    assign s1_valid  = s1_valid_reg;
    assign s1_item   = item_reg;

    assign h_ext  = {1'b0, cfg.height};
    assign ri_m1  = ri_reg - bnd_pkg::RCNT_BITS'(1);
    assign ri_m2  = ri_reg - bnd_pkg::RCNT_BITS'(2);
    assign ic_inc = {1'b0, ic_reg} + bnd_pkg::WCFG_BITS'(1);
    assign w_m1   = cfg.width - bnd_pkg::WCFG_BITS'(1);
    assign ic_m1  = ic_reg - bnd_pkg::COL_BITS'(1);

    // At column zero, from the third row on, the last pixel of the row two rows back completes;
    // elsewhere, from the second row on, the pixel one row and one column back completes.
    always_comb
    begin
        item_next           = '0;
        item_next.addr      = ic_reg;
        item_next.px        = pixel_black && !drain && (ri_reg < h_ext);
        item_next.emit_prev = (ic_reg == '0) && (ri_reg >= bnd_pkg::RCNT_BITS'(2));
        if (item_next.emit_prev)
        begin
            item_next.emit = 1'b1;
            item_next.oc   = w_m1[bnd_pkg::COL_BITS-1:0];
            item_next.orow = ri_m2[bnd_pkg::ROW_BITS-1:0];
            item_next.lv   = (cfg.width != bnd_pkg::WCFG_BITS'(1));
            item_next.rv   = 1'b0;
            item_next.up   = (ri_reg > bnd_pkg::RCNT_BITS'(2));
            item_next.dn   = (ri_reg <= h_ext);
            item_next.last = (ri_reg == (h_ext + bnd_pkg::RCNT_BITS'(1)));
        end
        else if ((ic_reg != '0) && (ri_reg != '0))
        begin
            item_next.emit = 1'b1;
            item_next.oc   = ic_m1;
            item_next.orow = ri_m1[bnd_pkg::ROW_BITS-1:0];
            item_next.lv   = (ic_reg > bnd_pkg::COL_BITS'(1));
            item_next.rv   = 1'b1;
            item_next.up   = (ri_reg > bnd_pkg::RCNT_BITS'(1));
            item_next.dn   = (ri_reg < h_ext);
            item_next.last = 1'b0;
        end
    end

    always_comb
    begin
        if (item_next.last)
        begin
            ic_next = '0;
            ri_next = '0;
        end
        else if (ic_inc == cfg.width)
        begin
            ic_next = '0;
            ri_next = ri_reg + bnd_pkg::RCNT_BITS'(1);
        end
        else
        begin
            ic_next = ic_inc[bnd_pkg::COL_BITS-1:0];
            ri_next = ri_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ic_reg       <= '0;
            ri_reg       <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg.restart)
            begin
                ic_reg <= '0;
                ri_reg <= '0;
            end
            else if (take)
            begin
                ic_reg <= ic_next;
                ri_reg <= ri_next;
            end
            if (take)
                s1_valid_reg <= 1'b1;
            else if (s1_go)
                s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            item_reg <= item_next;
    end

`ifndef SYNTHESIS
    a_col_in_row: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, ic_reg} < cfg.width))
        else $error("column counter beyond image width");
    a_row_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (ri_reg <= (h_ext + bnd_pkg::RCNT_BITS'(1))))
        else $error("row counter beyond last drain row");
    a_take_loads: assert property (@(posedge clk) disable iff (!rst_n)
        take |=> s1_valid_reg)
        else $error("accepted item lost before window stage");
`endif

endmodule

// ----- src/bnd_window_out.sv -----
// Window stage: merges line memory data, updates the 3x3 window and holds the result beat.
module bnd_window_out
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  bnd_pkg::cfg_t                 cfg,
    input  logic                          s1_valid,
    input  bnd_pkg::item_t                s1_item,
    output logic                          s1_go,
    input  logic [1:0]                    mem_rdata,
    output logic                          mem_wen,
    output logic [bnd_pkg::COL_BITS-1:0]  mem_waddr,
    output logic [1:0]                    mem_wdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [31:0]                   m_tdata,
    output logic                          m_tlast
);

    logic [8:0]                    window_reg, win_new;
    logic [2:0]                    col, left, mid, right;
    logic                          black;
    logic                          out_valid_reg, out_last_reg, out_black_reg;
    logic [bnd_pkg::COL_BITS-1:0]  out_col_reg;
    logic [bnd_pkg::ROW_BITS-1:0]  out_row_reg;
    logic                          out_free;

    assign out_free = !out_valid_reg || m_tready;
    assign s1_go    = s1_valid && (!s1_item.emit || out_free);

    assign col     = {s1_item.px, mem_rdata[0], mem_rdata[1]};
    assign win_new = {col, window_reg[8:3]};

    assign mem_wen   = s1_go;
    assign mem_waddr = s1_item.addr;
    assign mem_wdata = {mem_rdata[0], s1_item.px};

    always_comb
    begin
        if (s1_item.emit_prev)
        begin
            left  = window_reg[5:3];
            mid   = window_reg[8:6];
            right = 3'd0;
        end
        else
        begin
            left  = win_new[2:0];
            mid   = win_new[5:3];
            right = win_new[8:6];
        end
        black = bnd_pkg::dilate(left, mid, right, s1_item.lv, s1_item.rv,
                                s1_item.up, s1_item.dn, cfg.eight_connected);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg.restart)
                window_reg <= '0;
            else if (s1_go)
                window_reg <= s1_item.last ? 9'd0 : win_new;
            if (s1_go && s1_item.emit)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_go && s1_item.emit)
        begin
            out_col_reg   <= s1_item.oc;
            out_row_reg   <= s1_item.orow;
            out_black_reg <= black;
            out_last_reg  <= s1_item.last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {{(32 - bnd_pkg::COL_BITS - bnd_pkg::ROW_BITS - 1){1'b0}},
                       out_black_reg, out_row_reg, out_col_reg};

endmodule

// ----- src/binary_neighbour_dilation_unit.sv -----
// Top level of the streaming 3x3 binary dilation unit.
// Latency: two register stages, the scan stage item register and then the output register
// that drives m_tvalid. Throughput: one beat per cycle, since the line memory
// reads the next column on its read port while the previous one is written back on its
// write port; s_tready drops only while a result beat waits on m_tready and the held beat
// owes another. Reset clears counters, window and output valid; stale rows are masked.
module binary_neighbour_dilation_unit
(
    input  logic                          clk,
    input  logic                          rst_n,
    // Input stream: tdata bit 0 pixel_black, rest zero; tuser bit 0 req_type.
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,
    input  logic                          s_tuser,
    // Output stream: tdata bits [9:0] out_col, [25:10] out_row, [26] out_black.
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [31:0]                   m_tdata,
    output logic                          m_tlast,
    // Configuration port.
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bnd_pkg::ADDR_BITS-1:0] paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    bnd_pkg::cfg_t                 cfg;
    bnd_pkg::item_t                s1_item;
    logic                          s1_valid;
    logic                          s1_go;
    logic                          mem_ren;
    logic [bnd_pkg::COL_BITS-1:0]  mem_raddr;
    logic [1:0]                    mem_rdata;
    logic                          mem_wen;
    logic [bnd_pkg::COL_BITS-1:0]  mem_waddr;
    logic [1:0]                    mem_wdata;

    // Register block: clamps geometry and pulses a restart on geometry writes,
    // which drops any partial image.
    bnd_cfg_regs u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Scan stage: tracks the raster position of each beat, decides which output
    // pixel it completes, and issues the line memory read for its column.
    bnd_raster_ctrl u_ctrl
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .req_type    (s_tuser),
        .pixel_black (s_tdata[0]),
        .s1_go       (s1_go),
        .s1_valid    (s1_valid),
        .s1_item     (s1_item),
        .mem_ren     (mem_ren),
        .mem_raddr   (mem_raddr)
    );

    // Line memory: the two rows above the incoming one. A write and a read of the
    // same column in one cycle (one-pixel rows, or the first beat of an image right
    // after the last result of the previous one) passes the new data through.
    bnd_line_mem u_mem
    (
        .clk   (clk),
        .ren   (mem_ren),
        .raddr (mem_raddr),
        .rdata (mem_rdata),
        .wen   (mem_wen),
        .waddr (mem_waddr),
        .wdata (mem_wdata)
    );

    // Window stage: shifts the new column in, writes the rows back, evaluates the
    // neighbour test and holds the result beat so the scan stage keeps accepting.
    bnd_window_out u_win
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .s1_valid  (s1_valid),
        .s1_item   (s1_item),
        .s1_go     (s1_go),
        .mem_rdata (mem_rdata),
        .mem_wen   (mem_wen),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule
